// ===== rtl/sua_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating unsigned ALU package
// Shared widths, operation codes and the divider stage record.
// ----------------------------------------------------------------------------
package sua_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int HALF_WIDTH = DATA_WIDTH / 2;
  localparam int DIV_STAGES = DATA_WIDTH;
  localparam int MUL_LAT    = 4;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  // One slot of the main pipeline: control, early result and divider state.
  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    logic [DATA_WIDTH-1:0] fast;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] dvd;
    logic [DATA_WIDTH-1:0] dvs;
    logic [DATA_WIDTH-1:0] quo;
  } div_stage_t;

endpackage

// ===== rtl/sua_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating unsigned ALU channels
// Operation channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sua_in_if import sua_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [DATA_WIDTH-1:0] operand_a;
  logic [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, output kind, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input kind, input operand_a, input operand_b,
                  output ready);
endinterface

interface sua_out_if import sua_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ===== rtl/sua_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating multiplier
// Four-stage pipeline built from four half-width partial products.
// ----------------------------------------------------------------------------
module sua_mul import sua_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DATA_WIDTH-1:0] mul_a,
  input  logic [DATA_WIDTH-1:0] mul_b,
  output logic [DATA_WIDTH-1:0] mul_res
);

  logic [DATA_WIDTH-1:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [DATA_WIDTH:0]   mid_r;
  logic [DATA_WIDTH-1:0] ll2_r;
  logic                  hh_nz_r, hh_nz3_r;
  logic [DATA_WIDTH:0]   lo_r;
  logic [HALF_WIDTH:0]   hi_part_r;
  logic [DATA_WIDTH-1:0] res_r;

  logic [DATA_WIDTH:0]   lo_nxt;
  logic                  ovf_nxt;

  // Low sum and overflow detection for the last two stages.
  always_comb begin
    lo_nxt  = {1'b0, ll2_r} + {1'b0, mid_r[HALF_WIDTH-1:0], {HALF_WIDTH{1'b0}}};
    ovf_nxt = hh_nz3_r | (|hi_part_r) | lo_r[DATA_WIDTH];
  end

  // Payload-only pipeline; valid bits travel in the divider chain.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r   <= mul_a[HALF_WIDTH-1:0] * mul_b[HALF_WIDTH-1:0];
      pp_lh_r   <= mul_a[HALF_WIDTH-1:0] * mul_b[DATA_WIDTH-1:HALF_WIDTH];
      pp_hl_r   <= mul_a[DATA_WIDTH-1:HALF_WIDTH] * mul_b[HALF_WIDTH-1:0];
      pp_hh_r   <= mul_a[DATA_WIDTH-1:HALF_WIDTH] * mul_b[DATA_WIDTH-1:HALF_WIDTH];
      mid_r     <= {1'b0, pp_lh_r} + {1'b0, pp_hl_r};
      ll2_r     <= pp_ll_r;
      hh_nz_r   <= |pp_hh_r;
      lo_r      <= lo_nxt;
      hi_part_r <= mid_r[DATA_WIDTH:HALF_WIDTH];
      hh_nz3_r  <= hh_nz_r;
      res_r     <= ovf_nxt ? {DATA_WIDTH{1'b1}} : lo_r[DATA_WIDTH-1:0];
    end
  end

  assign mul_res = res_r;

endmodule

// ===== rtl/sua_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider pipeline
// Restoring division, one quotient bit per stage; also carries every item.
// ----------------------------------------------------------------------------
module sua_div import sua_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  div_stage_t            head,
  input  logic [DATA_WIDTH-1:0] mul_res,
  output div_stage_t            tail
);

  div_stage_t pipe_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_stage_t          prev;
    div_stage_t          step_nxt;
    logic [DATA_WIDTH:0] trial;

    if (k == 0) begin : g_first
      assign prev = head;
    end else begin : g_next
      assign prev = pipe_r[k-1];
    end

    // Trial subtract of the divisor from the shifted partial remainder.
    always_comb begin
      step_nxt = prev;
      trial    = {prev.rem, prev.dvd[DATA_WIDTH-1]} - {1'b0, prev.dvs};
      step_nxt.dvd = {prev.dvd[DATA_WIDTH-2:0], 1'b0};
      if (!trial[DATA_WIDTH]) begin
        step_nxt.rem = trial[DATA_WIDTH-1:0];
        step_nxt.quo = {prev.quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
        step_nxt.rem = {prev.rem[DATA_WIDTH-2:0], prev.dvd[DATA_WIDTH-1]};
        step_nxt.quo = {prev.quo[DATA_WIDTH-2:0], 1'b0};
      end
      // The multiplier result lines up with this stage.
      if (k == MUL_LAT && prev.kind == KIND_MUL) begin
        step_nxt.fast = mul_res;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[k].valid <= 1'b0;
      end else if (en) begin
        pipe_r[k] <= step_nxt;
      end
    end
  end

  assign tail = pipe_r[DIV_STAGES-1];

  // A zero divisor leaves an all-ones quotient, which is the saturated value.
  a_div_zero_max: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.valid && tail.kind == KIND_DIV && tail.dvs == '0) |-> (&tail.quo))
    else $error("divide by zero did not give the maximum");

endmodule

// ===== rtl/saturating_unsigned_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating unsigned ALU
// Add, subtract, multiply and divide on unsigned operands with saturation.
//
//   Channel  Direction  Fields
//   in_ch    sink       kind, operand_a, operand_b
//   out_ch   source     result
//
// One item enters per cycle while the output is not stalled; each result passes
// through one entry stage and then one divider stage per quotient bit.
// The divider chain sets the latency; all operations share it, so order holds.
// Synchronous active-low reset clears only the valid bits.
// A stalled output freezes the whole pipeline; in_ch.ready stays high while
// the last stage is empty or out_ch.ready is high.
// ----------------------------------------------------------------------------
module saturating_unsigned_alu import sua_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sua_in_if.sink    in_ch,
  sua_out_if.source out_ch
);

  div_stage_t            s0_r;
  div_stage_t            s0_nxt;
  div_stage_t            tail;
  logic                  en;
  logic [DATA_WIDTH-1:0] mul_res;
  logic [DATA_WIDTH:0]   sum;
  logic [DATA_WIDTH:0]   diff;

  assign en = !tail.valid || out_ch.ready;

  // Entry stage: add and subtract finish here.
  always_comb begin
    sum  = {1'b0, in_ch.operand_a} + {1'b0, in_ch.operand_b};
    diff = {1'b0, in_ch.operand_a} - {1'b0, in_ch.operand_b};
    s0_nxt       = '0;
    s0_nxt.valid = in_ch.valid;
    s0_nxt.kind  = kind_t'(in_ch.kind);
    s0_nxt.dvd   = in_ch.operand_a;
    s0_nxt.dvs   = in_ch.operand_b;
    case (kind_t'(in_ch.kind))
      KIND_ADD: s0_nxt.fast = sum[DATA_WIDTH] ? {DATA_WIDTH{1'b1}} : sum[DATA_WIDTH-1:0];
      KIND_SUB: s0_nxt.fast = diff[DATA_WIDTH] ? '0 : diff[DATA_WIDTH-1:0];
      default:  s0_nxt.fast = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (en) begin
      s0_r <= s0_nxt;
    end
  end

  sua_mul u_mul (
    .clk     (clk),
    .en      (en),
    .mul_a   (s0_r.dvd),
    .mul_b   (s0_r.dvs),
    .mul_res (mul_res)
  );

  sua_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .head    (s0_r),
    .mul_res (mul_res),
    .tail    (tail)
  );

  // Output selection from the last stage.
  assign in_ch.ready   = en;
  assign out_ch.valid  = tail.valid;
  assign out_ch.result = (tail.kind == KIND_DIV) ? tail.quo : tail.fast;

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output side was ready");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result offered right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.valid && !out_ch.ready) |=> (tail.valid && $stable(tail.kind)))
    else $error("last stage changed during a stall");

endmodule

// ===== sim/saturating_unsigned_alu_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating unsigned ALU regression
// Drives operations through the input channel, predicts each saturated or
// clamped result and compares it with every output transfer in order.
// ----------------------------------------------------------------------------
module saturating_unsigned_alu_test;
  import sua_pkg::*;

  localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;
  localparam int LATENCY   = 65;
  localparam int MAX_CYCLES = 400000;
  localparam int HOLD_LEN   = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sua_in_if  in_ch ();
  sua_out_if out_ch ();

  saturating_unsigned_alu uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Expected results, oldest first.
  logic [DATA_WIDTH-1:0] pending_results[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_cycles = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturating arithmetic at the block's width.
  function automatic logic [DATA_WIDTH-1:0] saturating_result(
      kind_t op, logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
    logic [DATA_WIDTH:0]     sum;
    logic [2*DATA_WIDTH-1:0] prod;
    case (op)
      KIND_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        return sum[DATA_WIDTH] ? ALL_ONES : sum[DATA_WIDTH-1:0];
      end
      KIND_SUB: begin
        return (a >= b) ? a - b : '0;
      end
      KIND_MUL: begin
        prod = {{DATA_WIDTH{1'b0}}, a} * {{DATA_WIDTH{1'b0}}, b};
        return (prod[2*DATA_WIDTH-1:DATA_WIDTH] != '0) ? ALL_ONES
                                                        : prod[DATA_WIDTH-1:0];
      end
      default: begin
        return (b == '0) ? ALL_ONES : a / b;
      end
    endcase
  endfunction

  function automatic logic [DATA_WIDTH-1:0] random_word();
    logic [DATA_WIDTH-1:0] w;
    int shape;
    w = {$urandom(), $urandom()};
    shape = $urandom_range(0, 7);
    case (shape)
      0: return w >> $urandom_range(0, DATA_WIDTH - 1);
      1: return w >> $urandom_range(DATA_WIDTH / 2, DATA_WIDTH - 1);
      2: return ALL_ONES - DATA_WIDTH'($urandom_range(0, 3));
      3: return DATA_WIDTH'($urandom_range(0, 3));
      4: return ALL_ONES >> $urandom_range(0, DATA_WIDTH - 1);
      default: return w;
    endcase
  endfunction

  // Sends one operation and records its expected result at the transfer.
  task automatic send_op(kind_t op, logic [DATA_WIDTH-1:0] a,
                         logic [DATA_WIDTH-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(saturating_result(op, a, b));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Extremes of the operands for every operation, plus the special cases.
  task automatic test_directed();
    kind_t op;
    for (int k = 0; k < 4; k++) begin
      op = kind_t'(k);
      send_op(op, '0, '0);
      send_op(op, ALL_ONES, ALL_ONES);
      send_op(op, ALL_ONES, DATA_WIDTH'(1));
      send_op(op, DATA_WIDTH'(1), ALL_ONES);
    end
    send_op(KIND_ADD, ALL_ONES - DATA_WIDTH'(5), DATA_WIDTH'(5));
    send_op(KIND_ADD, ALL_ONES - DATA_WIDTH'(5), DATA_WIDTH'(6));
    send_op(KIND_SUB, DATA_WIDTH'(7), DATA_WIDTH'(8));
    send_op(KIND_MUL, 64'h1_0000_0000, 64'hFFFF_FFFF);
    send_op(KIND_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
    send_op(KIND_DIV, DATA_WIDTH'(12345), '0);
    send_op(KIND_DIV, DATA_WIDTH'(100), DATA_WIDTH'(7));
    wait_drained();
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      send_op(kind_t'($urandom_range(0, 3)), random_word(), random_word());
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    test_random(120, 0, 0);
    wait_drained();
  endtask

  // Output side: stalls at random, checks each transfer.
  always @(negedge clk) begin
    if (hold_req && hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_ch.result);
      end else begin
        if (out_ch.result !== pending_results[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected %h actual %h",
                     pending_results[0], out_ch.result);
          end
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("saturating_unsigned_alu regression: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.kind      = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(340, 38, 68);
    wait_drained();
    test_random(340, 68, 38);
    test_backpressure();
    test_random(230, 0, 0);
    wait_drained();
    repeat (LATENCY) @(negedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("saturating_unsigned_alu regression: pass");
    end else begin
      $display("saturating_unsigned_alu regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sua_pkg.sv
rtl/sua_if.sv
rtl/sua_mul.sv
rtl/sua_div.sv
rtl/saturating_unsigned_alu.sv
sim/saturating_unsigned_alu_test.sv
